// ===== rtl/core/rfgc_pkg.sv =====
package rfgc_pkg;

  localparam int ByteW      = 8;
  localparam int GroupSize  = 8;
  localparam int GrpCntW    = $clog2(GroupSize);
  // a full group plus a one-token flush group: 1 + 8 + 1 + 1 bytes
  localparam int ObufDepth  = 11;
  localparam int ObufCntW   = $clog2(ObufDepth + 1);
  localparam int MergeDepth = GroupSize + 1;

  localparam logic [ByteW-1:0] RunCap   = 8'd255;
  localparam logic [ByteW-1:0] FlagTop  = 8'h80;

  typedef struct packed {
    logic             valid;
    logic             lit;
    logic [ByteW-1:0] payload;
  } token_t;

endpackage

// ===== rtl/core/rfgc_in_if.sv =====
interface rfgc_in_if;
  logic                        valid;
  logic                        ready;
  logic [rfgc_pkg::ByteW-1:0]  in_byte;
  logic                        block_end;

  modport source (output valid, output in_byte, output block_end, input ready);
  modport sink   (input valid, input in_byte, input block_end, output ready);
endinterface

// ===== rtl/core/rfgc_out_if.sv =====
interface rfgc_out_if;
  logic                        valid;
  logic                        ready;
  logic [rfgc_pkg::ByteW-1:0]  out_byte;
  logic                        last_of_item;
  logic                        stream_end;

  modport source (output valid, output out_byte, output last_of_item,
                  output stream_end, input ready);
  modport sink   (input valid, input out_byte, input last_of_item,
                  input stream_end, output ready);
endinterface

// ===== rtl/core/rle_flag_group_compressor_unit.sv =====
// The first output byte of an item is valid in the cycle after the item is accepted.
// Items that produce no bytes are accepted back to back; an item producing N bytes (up to 11)
// holds the output port until all N have left, one byte per cycle while out_o.ready is high,
// and the next item is taken in the cycle its last byte leaves.
// Reset (rst_ni low, asynchronous): predictor, run count, group flags and counts and the
// output buffer count clear at once; no clearing pass is needed.
module rle_flag_group_compressor_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  rfgc_in_if.sink     in_i,
  rfgc_out_if.source  out_o
);

  localparam int BW = rfgc_pkg::ByteW;
  localparam int GS = rfgc_pkg::GroupSize;
  localparam int MD = rfgc_pkg::MergeDepth;
  localparam int OD = rfgc_pkg::ObufDepth;
  localparam int GW = rfgc_pkg::GrpCntW;
  localparam int OW = rfgc_pkg::ObufCntW;

  // ---------------------------------------------------------------------------
  // Compressor state
  // ---------------------------------------------------------------------------
  logic [BW-1:0] pred_q, pred_d;
  logic          pred_vld_q, pred_vld_d;
  logic [BW-1:0] run_q, run_d;          // 0 means no open run
  logic [BW-1:0] grp_pay_q [GS];        // payload slots, only slots below grp_cnt_q are valid
  logic [BW-1:0] grp_pay_d [GS];
  logic [GS-1:0] grp_flag_q, grp_flag_d; // MSB first, bits past the count stay 0
  logic [GW-1:0] grp_cnt_q, grp_cnt_d;

  // Output buffer: shifts down by one byte per pop, head at entry 0
  logic [BW-1:0] ob_q [OD];
  logic [BW-1:0] ob_d [OD];
  logic [OW-1:0] ob_cnt_q, ob_cnt_d;
  logic          end_q, end_d;

  logic accept;
  logic pop;

  assign pop       = out_o.valid && out_o.ready;
  // Take a new item once the buffer is empty or its last byte leaves now
  assign in_i.ready = (ob_cnt_q == '0) || ((ob_cnt_q == OW'(1)) && out_o.ready);
  assign accept    = in_i.valid && in_i.ready;

  assign out_o.valid        = (ob_cnt_q != '0);
  assign out_o.out_byte     = ob_q[0];
  assign out_o.last_of_item = (ob_cnt_q == OW'(1));
  assign out_o.stream_end   = (ob_cnt_q == OW'(1)) && end_q;

  // ---------------------------------------------------------------------------
  // Token generation: at most two tokens per item (closed run, then literal)
  // ---------------------------------------------------------------------------
  rfgc_pkg::token_t tok0, tok1;
  logic             hit;
  logic [BW-1:0]    run_inc;
  logic [BW-1:0]    run_nxt;
  logic [1:0]       tok_num;
  logic [GW:0]      merged_cnt;   // n + k, 0..9
  logic             full;
  logic [BW-1:0]    ext_pay [MD];
  logic             ext_lit [MD];
  logic [GS-1:0]    flag_byte;
  logic [OW-1:0]    new_ob_cnt;
  logic [GW:0]      n_ext;

  always_comb begin
    hit     = pred_vld_q && (in_i.in_byte == pred_q);
    run_inc = run_q + BW'(1);
    tok0    = '0;
    tok1    = '0;
    run_nxt = '0;
    if (hit) begin
      run_nxt = run_inc;
      if (run_inc == rfgc_pkg::RunCap) begin
        // run hit its cap: close it now
        tok0    = '{valid: 1'b1, lit: 1'b0, payload: rfgc_pkg::RunCap};
        run_nxt = '0;
      end else if (in_i.block_end) begin
        tok0    = '{valid: 1'b1, lit: 1'b0, payload: run_inc};
        run_nxt = '0;
      end
    end else if (run_q != '0) begin
      tok0 = '{valid: 1'b1, lit: 1'b0, payload: run_q};
      tok1 = '{valid: 1'b1, lit: 1'b1, payload: in_i.in_byte};
    end else begin
      tok0 = '{valid: 1'b1, lit: 1'b1, payload: in_i.in_byte};
    end
    tok_num = {1'b0, tok0.valid} + {1'b0, tok1.valid};
  end

  // Append the new tokens behind the stored group
  always_comb begin
    n_ext      = {1'b0, grp_cnt_q};
    merged_cnt = n_ext + (GW+1)'(tok_num);
    for (int i = 0; i < MD; i++) begin
      if ((GW+1)'(i) < n_ext) begin
        ext_pay[i] = grp_pay_q[i];
        ext_lit[i] = grp_flag_q[GS-1-i];
      end else if ((GW+1)'(i) == n_ext) begin
        ext_pay[i] = tok0.payload;
        ext_lit[i] = tok0.valid && tok0.lit;
      end else if ((GW+1)'(i) == n_ext + (GW+1)'(1)) begin
        ext_pay[i] = tok1.payload;
        ext_lit[i] = tok1.valid && tok1.lit;
      end else begin
        ext_pay[i] = '0;
        ext_lit[i] = 1'b0;
      end
    end
    for (int i = 0; i < GS; i++) begin
      flag_byte[GS-1-i] = ext_lit[i];
    end
    full = (merged_cnt >= (GW+1)'(GS));
    // full group: flag + 8 payloads, and on block end the one spill token as its own group
    if (full) begin
      if (in_i.block_end && (merged_cnt == (GW+1)'(GS + 1))) begin
        new_ob_cnt = OW'(OD);
      end else begin
        new_ob_cnt = OW'(GS + 1);
      end
    end else if (in_i.block_end && (merged_cnt != '0)) begin
      new_ob_cnt = OW'(merged_cnt) + OW'(1);
    end else begin
      new_ob_cnt = '0;
    end
  end

  // ---------------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------------
  always_comb begin
    pred_d     = pred_q;
    pred_vld_d = pred_vld_q;
    run_d      = run_q;
    grp_pay_d  = grp_pay_q;
    grp_flag_d = grp_flag_q;
    grp_cnt_d  = grp_cnt_q;
    ob_d       = ob_q;
    ob_cnt_d   = ob_cnt_q;
    end_d      = end_q;

    if (pop) begin
      for (int i = 0; i < OD - 1; i++) begin
        ob_d[i] = ob_q[i+1];
      end
      ob_cnt_d = ob_cnt_q - OW'(1);
    end

    if (accept) begin
      // output buffer load, layout is fixed: flag, 8 payloads, spill flag, spill payload
      ob_d[0] = flag_byte;
      for (int i = 0; i < GS; i++) begin
        ob_d[i+1] = ext_pay[i];
      end
      ob_d[GS+1] = ext_lit[GS] ? rfgc_pkg::FlagTop : '0;
      ob_d[GS+2] = ext_pay[GS];
      ob_cnt_d   = new_ob_cnt;
      end_d      = in_i.block_end;

      if (full) begin
        grp_pay_d[0] = ext_pay[GS];
        grp_flag_d   = ext_lit[GS] ? rfgc_pkg::FlagTop : '0;
        grp_cnt_d    = GW'(merged_cnt - (GW+1)'(GS));
      end else begin
        for (int i = 0; i < GS; i++) begin
          grp_pay_d[i] = ext_pay[i];
        end
        grp_flag_d = flag_byte;
        grp_cnt_d  = merged_cnt[GW-1:0];
      end
      run_d = run_nxt;
      if (!hit) begin
        pred_d     = in_i.in_byte;
        pred_vld_d = 1'b1;
      end

      if (in_i.block_end) begin
        // block done: predictor, run count, group flags and group count back to reset values
        pred_d     = '0;
        pred_vld_d = 1'b0;
        run_d      = '0;
        grp_flag_d = '0;
        grp_cnt_d  = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pred_q     <= '0;
      pred_vld_q <= 1'b0;
      run_q      <= '0;
      grp_flag_q <= '0;
      grp_cnt_q  <= '0;
      ob_cnt_q   <= '0;
      end_q      <= 1'b0;
    end else begin
      pred_q     <= pred_d;
      pred_vld_q <= pred_vld_d;
      run_q      <= run_d;
      grp_flag_q <= grp_flag_d;
      grp_cnt_q  <= grp_cnt_d;
      ob_cnt_q   <= ob_cnt_d;
      end_q      <= end_d;
    end
  end

  // payload storage, no reset needed
  always_ff @(posedge clk_i) begin
    grp_pay_q <= grp_pay_d;
    ob_q      <= ob_d;
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_obuf_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ob_cnt_q <= OW'(OD))
    else $error("output buffer count out of range");

  a_run_below_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_q != rfgc_pkg::RunCap)
    else $error("open run reached cap without closing");

  a_flags_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (grp_flag_q & (8'hFF >> grp_cnt_q)) == '0)
    else $error("flag bit set past group count");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> (ob_cnt_q == '0) || (pop && (ob_cnt_q == OW'(1))))
    else $error("item accepted over pending output");

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_i.block_end) |=> (grp_cnt_q == '0) && !pred_vld_q && (run_q == '0))
    else $error("block end did not clear state");

endmodule

// ===== tb/sv/rle_flag_group_compressor_unit_tb.sv =====
`timescale 1ns / 100ps

module rle_flag_group_compressor_unit_tb;

  // One compressed byte as it should leave the block.
  typedef struct packed {
    logic [rfgc_pkg::ByteW-1:0] data;
    logic                       last;
    logic                       send;
  } comp_byte_t;

  // Receiver stall patterns; each holds for a random stretch of cycles.
  typedef enum logic [1:0] {
    RDY_ALWAYS,
    RDY_MOSTLY,
    RDY_SPARSE,
    RDY_PERIODIC
  } ready_mode_e;

  // Predicts the compressed stream and checks the bytes that come out.
  // Tokens are gathered eight to a group; a group leaves as a flag byte
  // (MSB first, 1 = literal) followed by its payloads.
  class rle_byte_scoreboard;
    comp_byte_t                 expected_bytes_q[$];
    comp_byte_t                 item_bytes_q[$];
    logic [rfgc_pkg::ByteW-1:0] last_literal;
    bit                         last_literal_valid;
    logic [rfgc_pkg::ByteW-1:0] run_count;
    logic [rfgc_pkg::ByteW-1:0] group_payload[rfgc_pkg::GroupSize];
    logic [rfgc_pkg::ByteW-1:0] group_flags;
    int unsigned                group_fill;
    int unsigned                mismatches;

    function new();
      mismatches = 0;
      clear_state();
    endfunction

    function void clear_state();
      last_literal       = '0;
      last_literal_valid = 1'b0;
      run_count          = '0;
      group_flags        = '0;
      group_fill         = 0;
      foreach (group_payload[k]) group_payload[k] = '0;
    endfunction

    function void push_byte(logic [rfgc_pkg::ByteW-1:0] b);
      comp_byte_t rec;
      rec.data = b;
      rec.last = 1'b0;
      rec.send = 1'b0;
      item_bytes_q.insert(item_bytes_q.size(), rec);
    endfunction

    function void flush_group();
      if (group_fill == 0) return;
      push_byte(group_flags);
      for (int k = 0; k < group_fill; k++) push_byte(group_payload[k]);
      group_flags = '0;
      group_fill  = 0;
    endfunction

    function void add_token(bit is_literal, logic [rfgc_pkg::ByteW-1:0] payload);
      group_payload[group_fill] = payload;
      if (is_literal) group_flags = group_flags | (rfgc_pkg::FlagTop >> group_fill);
      group_fill++;
      if (group_fill == rfgc_pkg::GroupSize) flush_group();
    endfunction

    function void close_run();
      if (run_count != '0) begin
        add_token(1'b0, run_count);
        run_count = '0;
      end
    endfunction

    // Accepted raw byte: queue up every compressed byte it causes.
    function void note_raw_byte(logic [rfgc_pkg::ByteW-1:0] b, logic block_end);
      int idx;
      item_bytes_q.delete();
      if (last_literal_valid && b == last_literal) begin
        run_count = run_count + 1'b1;
        if (run_count == rfgc_pkg::RunCap) close_run();
      end else begin
        close_run();
        add_token(1'b1, b);
        last_literal       = b;
        last_literal_valid = 1'b1;
      end
      if (block_end) begin
        close_run();
        flush_group();
        clear_state();
      end
      if (item_bytes_q.size() > 0) begin
        idx = item_bytes_q.size() - 1;
        item_bytes_q[idx].last = 1'b1;
        item_bytes_q[idx].send = block_end;
      end
      foreach (item_bytes_q[k])
        expected_bytes_q.insert(expected_bytes_q.size(), item_bytes_q[k]);
    endfunction

    function void report(string msg);
      mismatches++;
      if (mismatches <= 10) $display("[%0t] mismatch: %s", $realtime, msg);
    endfunction

    function void check_out_byte(logic [rfgc_pkg::ByteW-1:0] b, logic last, logic send);
      comp_byte_t exp_rec;
      if (expected_bytes_q.size() == 0) begin
        report($sformatf("unexpected byte %02h last=%b end=%b", b, last, send));
        return;
      end
      exp_rec = expected_bytes_q.pop_front();
      if (b !== exp_rec.data)
        report($sformatf("out_byte exp %02h got %02h", exp_rec.data, b));
      if (last !== exp_rec.last)
        report($sformatf("last_of_item exp %b got %b (byte %02h)", exp_rec.last, last, b));
      if (send !== exp_rec.send)
        report($sformatf("stream_end exp %b got %b (byte %02h)", exp_rec.send, send, b));
    endfunction

    function int pending();
      return expected_bytes_q.size();
    endfunction

    function bit failed();
      return mismatches != 0;
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  rfgc_in_if  in_bus ();
  rfgc_out_if out_bus ();

  rle_flag_group_compressor_unit u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus.sink),
    .out_o  (out_bus.source)
  );

  rle_byte_scoreboard sb;

  // Sender burst state: items left in the current burst, and whether
  // gaps are allowed at all in the current stretch.
  int unsigned burst_left;
  bit          gaps_on;
  int unsigned random_items;

  // Receiver stall pattern state.
  ready_mode_e ready_mode = RDY_ALWAYS;
  int unsigned ready_left = 0;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Hard stop: far beyond the slowest legal run of this stimulus.
  initial begin
    #1_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // Receiver: stall pattern switches mode at random intervals, including
  // stretches where it never stalls.
  always @(posedge clk_i) begin
    if (ready_left == 0) begin
      ready_mode <= ready_mode_e'($urandom_range(0, 3));
      ready_left <= $urandom_range(4, 40);
    end else begin
      ready_left <= ready_left - 1;
    end
    case (ready_mode)
      RDY_ALWAYS:   out_bus.ready <= 1'b1;
      RDY_MOSTLY:   out_bus.ready <= ($urandom_range(0, 3) != 0);
      RDY_SPARSE:   out_bus.ready <= ($urandom_range(0, 3) == 0);
      default:      out_bus.ready <= (ready_left[1:0] != 2'd0);
    endcase
  end

  // Output monitor: values read here are the ones present at the edge.
  always @(posedge clk_i) begin
    if (rst_ni && out_bus.valid && out_bus.ready)
      sb.check_out_byte(out_bus.out_byte, out_bus.last_of_item, out_bus.stream_end);
  end

  // Offer one raw byte and hold it until taken. Called at a rising edge;
  // returns at the edge that accepted it, or after the following gap.
  task automatic send_raw(input logic [rfgc_pkg::ByteW-1:0] b, input logic block_end);
    int unsigned gap;
    in_bus.valid     <= 1'b1;
    in_bus.in_byte   <= b;
    in_bus.block_end <= block_end;
    @(posedge clk_i);
    while (!in_bus.ready) @(posedge clk_i);
    sb.note_raw_byte(b, block_end);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      // end of burst: pick the next burst length and maybe idle a while
      burst_left = $urandom_range(0, 15);
      gap = gaps_on ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
        in_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // Hold off the sender until every predicted byte has been seen.
  task automatic drain_pause();
    in_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // Well-formed block: runs over a small alphabet so that runs, literals
  // and group boundaries all mix; block_end on the last byte.
  task automatic send_block(input int unsigned len);
    logic [rfgc_pkg::ByteW-1:0] base;
    logic [rfgc_pkg::ByteW-1:0] cur;
    int unsigned                run;
    base = 8'($urandom_range(0, 255));
    cur  = base;
    for (int unsigned i = 0; i < len; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: ;                                   // repeat: extend run
        5, 6, 7:       cur = base ^ 8'($urandom_range(0, 3));
        default:       cur = 8'($urandom_range(0, 255));
      endcase
      send_raw(cur, i == len - 1);
      random_items++;
    end
    // occasionally tack on a long run block to push counts high
    if ($urandom_range(0, 7) == 0) begin
      run = $urandom_range(20, 60);
      cur = 8'($urandom_range(0, 255));
      for (int unsigned i = 0; i < run; i++) begin
        send_raw(cur, i == run - 1);
        random_items++;
      end
    end
  endtask

  initial begin
    rst_ni           <= 1'b0;
    in_bus.valid     <= 1'b0;
    in_bus.in_byte   <= '0;
    in_bus.block_end <= 1'b0;
    sb           = new();
    burst_left   = 0;
    gaps_on      = 1'b1;
    random_items = 0;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part.
    // Single-byte block of 0x00: literal even though the predictor reg
    // reads zero, since no predictor is valid yet.
    send_raw(8'h00, 1'b1);
    send_raw(8'hFF, 1'b1);
    // Eight distinct literals with block end on the eighth: the group is
    // already full, so the end adds no flush bytes.
    send_raw(8'h01, 1'b0);
    send_raw(8'h02, 1'b0);
    send_raw(8'h04, 1'b0);
    send_raw(8'h08, 1'b0);
    send_raw(8'h10, 1'b0);
    send_raw(8'h20, 1'b0);
    send_raw(8'h40, 1'b0);
    send_raw(8'h80, 1'b1);
    // New block starts with the previous block's last byte: still a literal.
    send_raw(8'h80, 1'b0);
    send_raw(8'h80, 1'b0);
    send_raw(8'h80, 1'b0);
    send_raw(8'h7F, 1'b0);
    send_raw(8'h7F, 1'b0);
    send_raw(8'hAA, 1'b1);
    // Open run flushed by block end.
    send_raw(8'h11, 1'b0);
    send_raw(8'h11, 1'b0);
    send_raw(8'h11, 1'b1);
    drain_pause();

    // Long run: count hits the cap and closes itself, then a new run opens.
    gaps_on = 1'b0;
    for (int i = 0; i < 300; i++) send_raw(8'h5A, 1'b0);
    send_raw(8'h3C, 1'b1);
    drain_pause();

    // Random part: mostly well-formed blocks, some noise with random ends,
    // and now and then a full drain.
    while (random_items < 160) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 9))
        7: begin
          repeat ($urandom_range(1, 10)) begin
            send_raw(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
            random_items++;
          end
        end
        8: begin
          drain_pause();
          send_block($urandom_range(1, 4));
        end
        9:       send_block($urandom_range(9, 24));
        default: send_block($urandom_range(1, 12));
      endcase
    end

    in_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    // let any stray output show up before the verdict
    repeat (30) @(posedge clk_i);

    if (!sb.failed()) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== rle_flag_group_compressor_unit.f =====
rtl/core/rfgc_pkg.sv
rtl/core/rfgc_in_if.sv
rtl/core/rfgc_out_if.sv
rtl/core/rle_flag_group_compressor_unit.sv
tb/sv/rle_flag_group_compressor_unit_tb.sv
